/* hw/rtl/bvm_pkg.sv */
// Shared types and constants for the battery voltage monitor.
`timescale 1ns / 1ps
package bvm_pkg;

	localparam int unsigned SUM_W  = 18;
	localparam int unsigned PROD_W = 34;
	localparam int unsigned DIV_W  = PROD_W - 4;
	localparam int unsigned QDEPTH = 4;

	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		REG_INTERVAL = 3'd0,
		REG_GAIN     = 3'd1,
		REG_ALPHA    = 3'd2,
		REG_CRITICAL = 3'd3,
		REG_LOW      = 3'd4,
		REG_HYST     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] now_ms;
		logic [11:0] raw_code;
		logic [11:0] pin_millivolts;
	} req_t;

	typedef struct packed {
		logic        sampling;
		logic        updated;
		logic        valid_res;
		logic        low_flag;
		logic        critical_flag;
		logic [15:0] pack_mv;
		logic [14:0] cell_mv;
		logic [11:0] raw_average;
	} rsp_t;

	typedef struct packed {
		logic [15:0] pack_gain_q12;
		logic [8:0]  alpha_q8;
		logic [15:0] critical_mv;
		logic [15:0] low_mv;
		logic [11:0] hysteresis_mv;
	} back_cfg_t;

	typedef struct packed {
		logic             finish;
		logic             sampling;
		logic [SUM_W-1:0] raw_sum;
		logic [SUM_W-1:0] mv_sum;
	} cmd_t;

endpackage

/* hw/rtl/bvm_front.sv */
// Front end: burst pacing, sample accumulation and command issue.
`timescale 1ns / 1ps
module bvm_front #(
	parameter int unsigned SAMPLES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bvm_pkg::req_t req,
	input  logic [15:0]   interval_ms,
	output logic          push,
	output bvm_pkg::cmd_t cmd,
	input  logic          full
);
	import bvm_pkg::*;

	localparam int unsigned CNT_W = $clog2(SAMPLES + 1);

	logic [31:0]      last_tick_q;
	logic             open_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] raw_sum_q;
	logic [SUM_W-1:0] mv_sum_q;

	logic [31:0]      elapsed;
	logic             tick_open;
	logic [CNT_W-1:0] cnt_nx;
	logic [SUM_W-1:0] raw_nx;
	logic [SUM_W-1:0] mv_nx;
	logic             last_sample;
	logic             take_sample;

	assign req_ready   = !full;
	assign push        = req_valid && req_ready;
	assign elapsed     = req.now_ms - last_tick_q;
	assign tick_open   = !open_q && (elapsed >= {16'b0, interval_ms});
	assign cnt_nx      = cnt_q + 1'b1;
	assign raw_nx      = raw_sum_q + SUM_W'(req.raw_code);
	assign mv_nx       = mv_sum_q + SUM_W'(req.pin_millivolts);
	assign last_sample = (cnt_nx == CNT_W'(SAMPLES));
	assign take_sample = (req.kind == KIND_SAMPLE) && open_q;

	always_comb begin
		cmd.raw_sum = raw_nx;
		cmd.mv_sum  = mv_nx;
		cmd.finish  = take_sample && last_sample;
		case (req.kind)
			KIND_TICK:   cmd.sampling = open_q || tick_open;
			KIND_SAMPLE: cmd.sampling = open_q && !last_sample;
			default:     cmd.sampling = open_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tick_q <= '0;
			open_q      <= 1'b0;
			cnt_q       <= '0;
			raw_sum_q   <= '0;
			mv_sum_q    <= '0;
		end else if (push) begin
			case (req.kind)
				KIND_TICK: begin
					if (tick_open) begin
						last_tick_q <= req.now_ms;
						open_q      <= 1'b1;
						cnt_q       <= '0;
						raw_sum_q   <= '0;
						mv_sum_q    <= '0;
					end
				end
				default: begin
					if (take_sample) begin
						raw_sum_q <= raw_nx;
						mv_sum_q  <= mv_nx;
						if (last_sample) begin
							open_q <= 1'b0;
							cnt_q  <= '0;
						end else begin
							cnt_q <= cnt_nx;
						end
					end
				end
			endcase
		end
	end

endmodule

/* hw/rtl/bvm_fifo.sv */
// Command queue between the front end and the back end.
`timescale 1ns / 1ps
module bvm_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bvm_pkg::cmd_t cmd_in,
	output logic          full,
	input  logic          pop,
	output bvm_pkg::cmd_t cmd_out,
	output logic          empty
);
	import bvm_pkg::*;

	localparam int unsigned PW = $clog2(QDEPTH);

	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full    = (count_q == (PW + 1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign cmd_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/bvm_div.sv */
// Division by a fixed divisor through multiplication by its rounded-up reciprocal.
`timescale 1ns / 1ps
module bvm_div #(
	parameter int unsigned DIVISOR = 8,
	parameter int unsigned DW      = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	output logic          done,
	output logic [DW-1:0] quotient
);
	// With a shift of DW plus the ceiling of log2 of the divisor, the rounded-up reciprocal gives the
	// exact floor quotient for every dividend of DW bits.
	localparam int unsigned SH = DW + $clog2(DIVISOR);
	localparam int unsigned PW = 2 * DW + 1;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [DW:0] RECIP = RECIP_FULL[DW:0];

	logic [DW-1:0] quo_q;
	logic          done_q;
	logic [PW-1:0] prod;

	assign prod     = PW'(dividend) * PW'(RECIP);
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= DW'(prod >> SH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

endmodule

/* hw/rtl/bvm_back.sv */
// Back end: burst averaging, gain scaling, smoothing, flags and result register.
`timescale 1ns / 1ps
module bvm_back #(
	parameter int unsigned SAMPLES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bvm_pkg::back_cfg_t cfg,
	input  logic               empty,
	input  bvm_pkg::cmd_t      cmd,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output bvm_pkg::rsp_t      rsp
);
	import bvm_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL    = 8'b0000_0010,
		ST_DSTART = 8'b0000_0100,
		ST_DIV    = 8'b0000_1000,
		ST_EMUL   = 8'b0001_0000,
		ST_EADD   = 8'b0010_0000,
		ST_FLAG   = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [SUM_W-1:0] raw_sum_q;
	logic [SUM_W-1:0] mv_sum_q;
	logic [PROD_W-1:0] prod_q;
	logic [23:0]      read_q;
	logic [32:0]      m1_q;
	logic [32:0]      m2_q;
	logic [23:0]      filt_q;
	logic             have_q;
	logic             low_q;
	logic             crit_q;
	logic [11:0]      raw_avg_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             slot_free;
	logic             rsp_load;
	logic             div_start;
	logic             div_done;
	logic             raw_done;
	logic [DIV_W-1:0] mv_quo;
	logic [SUM_W-1:0] raw_quo;
	logic [8:0]       alpha_eff;
	logic [8:0]       alpha_inv;
	logic [33:0]      ema_sum;
	logic [23:0]      crit_set;
	logic [24:0]      crit_clr;
	logic [23:0]      low_set;
	logic [24:0]      low_clr;
	logic             crit_nx;
	logic             low_nx;
	rsp_t             status;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_load  = ((state_q == ST_IDLE) && pop && !cmd.finish) ||
		((state_q == ST_OUT) && slot_free);
	assign div_start = (state_q == ST_DSTART);
	assign alpha_eff = cfg.alpha_q8[8] ? 9'd256 : cfg.alpha_q8;
	assign alpha_inv = 9'd256 - alpha_eff;
	assign ema_sum   = {1'b0, m1_q} + {1'b0, m2_q};
	assign crit_set  = {cfg.critical_mv, 8'b0};
	assign crit_clr  = {17'(cfg.critical_mv) + 17'(cfg.hysteresis_mv), 8'b0};
	assign low_set   = {cfg.low_mv, 8'b0};
	assign low_clr   = {17'(cfg.low_mv) + 17'(cfg.hysteresis_mv), 8'b0};
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	bvm_div #(.DIVISOR(SAMPLES), .DW(DIV_W)) u_mv_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q[PROD_W-1:4]),
		.done     (div_done),
		.quotient (mv_quo)
	);

	bvm_div #(.DIVISOR(SAMPLES), .DW(SUM_W)) u_raw_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (raw_sum_q),
		.done     (raw_done),
		.quotient (raw_quo)
	);

	always_comb begin
		crit_nx = crit_q;
		if (!crit_q && (filt_q <= crit_set)) begin
			crit_nx = 1'b1;
		end else if (crit_q && ({1'b0, filt_q} > crit_clr)) begin
			crit_nx = 1'b0;
		end
		low_nx = low_q;
		if (!low_q && (filt_q <= low_set)) begin
			low_nx = 1'b1;
		end else if (low_q && ({1'b0, filt_q} > low_clr)) begin
			low_nx = 1'b0;
		end
	end

	always_comb begin
		status.sampling      = (state_q == ST_IDLE) && cmd.sampling;
		status.updated       = (state_q == ST_OUT);
		status.valid_res     = have_q;
		status.low_flag      = low_q;
		status.critical_flag = crit_q;
		status.pack_mv       = filt_q[23:8];
		status.cell_mv       = filt_q[23:9];
		status.raw_average   = raw_avg_q;
	end

	always_comb begin
		pop = 1'b0;
		if (state_q == ST_IDLE && !empty) begin
			pop = cmd.finish || slot_free;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				raw_sum_q <= cmd.raw_sum;
				mv_sum_q  <= cmd.mv_sum;
			end
			ST_MUL: begin
				prod_q <= PROD_W'(mv_sum_q) * PROD_W'(cfg.pack_gain_q12);
			end
			ST_DIV: begin
				if (div_done) begin
					read_q <= (mv_quo[DIV_W-1:24] != '0) ? 24'hFFFFFF : mv_quo[23:0];
				end
			end
			ST_EMUL: begin
				m1_q <= 33'(filt_q) * 33'(alpha_inv);
				m2_q <= 33'(read_q) * 33'(alpha_eff);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			filt_q      <= '0;
			have_q      <= 1'b0;
			low_q       <= 1'b0;
			crit_q      <= 1'b0;
			raw_avg_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_q       <= status;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && cmd.finish) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DSTART;
				end
				ST_DSTART: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done && raw_done) begin
						raw_avg_q <= raw_quo[11:0];
						state_q   <= ST_EMUL;
					end
				end
				ST_EMUL: begin
					if (!have_q) begin
						filt_q  <= read_q;
						have_q  <= 1'b1;
						state_q <= ST_FLAG;
					end else begin
						state_q <= ST_EADD;
					end
				end
				ST_EADD: begin
					filt_q  <= ema_sum[31:8];
					state_q <= ST_FLAG;
				end
				ST_FLAG: begin
					crit_q  <= crit_nx;
					low_q   <= low_nx;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/battery_voltage_monitor_top.sv */
// Top level of the battery voltage monitor with its register file.
`timescale 1ns / 1ps
// Each request is a time tick or an ADC sample and yields exactly one result. Ticks and
// samples that do not close a burst pass through the command queue straight into the
// result register, so they stream at one per cycle while results are taken and no burst
// is being closed. The sample that closes a burst holds the back end for the gain
// multiply, the division by SAMPLES as a reciprocal multiply, the smoothing multiply and
// add (no add when it seeds the filter), the flag update and the result load, and while
// the result waits for rsp_ready. A four-entry command queue lets the front end keep accepting requests meanwhile.
module battery_voltage_monitor_top #(
	parameter int unsigned SAMPLES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bvm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bvm_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import bvm_pkg::*;

	logic [15:0] interval_q;
	back_cfg_t   cfg_q;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	cmd_t        cmd_in;
	cmd_t        cmd_out;
	logic        wr_en;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q          <= 16'd100;
			cfg_q.pack_gain_q12 <= 16'd8192;
			cfg_q.alpha_q8      <= 9'd26;
			cfg_q.critical_mv   <= 16'd6400;
			cfg_q.low_mv        <= 16'd7000;
			cfg_q.hysteresis_mv <= 12'd200;
		end else if (wr_en) begin
			unique case (idx)
				REG_INTERVAL: interval_q          <= pwdata[15:0];
				REG_GAIN:     cfg_q.pack_gain_q12 <= pwdata[15:0];
				REG_ALPHA:    cfg_q.alpha_q8      <= pwdata[8:0];
				REG_CRITICAL: cfg_q.critical_mv   <= pwdata[15:0];
				REG_LOW:      cfg_q.low_mv        <= pwdata[15:0];
				REG_HYST:     cfg_q.hysteresis_mv <= pwdata[11:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_INTERVAL: prdata = {16'b0, interval_q};
			REG_GAIN:     prdata = {16'b0, cfg_q.pack_gain_q12};
			REG_ALPHA:    prdata = {23'b0, cfg_q.alpha_q8};
			REG_CRITICAL: prdata = {16'b0, cfg_q.critical_mv};
			REG_LOW:      prdata = {16'b0, cfg_q.low_mv};
			REG_HYST:     prdata = {20'b0, cfg_q.hysteresis_mv};
			default:      prdata = '0;
		endcase
	end

	bvm_front #(.SAMPLES(SAMPLES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.interval_ms (interval_q),
		.push        (push),
		.cmd         (cmd_in),
		.full        (full)
	);

	bvm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_in),
		.full    (full),
		.pop     (pop),
		.cmd_out (cmd_out),
		.empty   (empty)
	);

	bvm_back #(.SAMPLES(SAMPLES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.cmd       (cmd_out),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

/* verif/battery_voltage_monitor_top_tb.sv */
// Self-checking testbench for the battery voltage monitor: directed and random ticks and samples.
`timescale 1ns / 1ps
module battery_voltage_monitor_top_tb;
	import bvm_pkg::*;

	localparam int unsigned SAMPLES     = 8;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	battery_voltage_monitor_top #(.SAMPLES(SAMPLES)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Register values as the monitor currently holds them.
	logic [15:0] cfg_interval = 16'd100;
	logic [15:0] cfg_gain     = 16'd8192;
	logic [8:0]  cfg_alpha    = 9'd26;
	logic [15:0] cfg_crit     = 16'd6400;
	logic [15:0] cfg_low      = 16'd7000;
	logic [11:0] cfg_hyst     = 12'd200;

	// Predicted filter and burst state.
	logic [31:0] last_tick_ms = '0;
	logic        burst_open = 1'b0;
	logic [6:0]  burst_count = '0;
	logic [17:0] raw_sum = '0;
	logic [17:0] mv_sum = '0;
	logic [23:0] filtered_q8 = '0;
	logic        have_reading = 1'b0;
	logic        low_state = 1'b0;
	logic        critical_state = 1'b0;
	logic [11:0] last_raw_avg = '0;

	req_t        pending_requests[$];
	rsp_t        expected_readings[$];

	int unsigned error_count = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned queued_total = 0;
	int unsigned req_gap = 0;
	int unsigned req_calm = 0;
	int unsigned rsp_gap = 0;
	int unsigned rsp_calm = 0;
	logic        req_hold = 1'b0;
	logic        quiet_mode = 1'b0;
	logic        long_hold_done = 1'b0;
	logic [31:0] gen_ms = '0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic next_flag(logic cur, logic [15:0] thr);
		longint unsigned set_at;
		longint unsigned clr_at;
		set_at = 64'(thr) << 8;
		clr_at = (64'(thr) + 64'(cfg_hyst)) << 8;
		if (!cur && 64'(filtered_q8) <= set_at)
			return 1'b1;
		if (cur && 64'(filtered_q8) > clr_at)
			return 1'b0;
		return cur;
	endfunction

	function automatic rsp_t predict_reading(req_t r);
		rsp_t        o;
		logic [31:0] elapsed;
		logic [63:0] reading;
		logic [63:0] weight;
		logic        updated;
		updated = 1'b0;
		if (r.kind == KIND_TICK) begin
			elapsed = r.now_ms - last_tick_ms;
			if (!burst_open && elapsed >= 32'(cfg_interval)) begin
				last_tick_ms = r.now_ms;
				burst_open = 1'b1;
				burst_count = '0;
				raw_sum = '0;
				mv_sum = '0;
			end
		end else if (burst_open) begin
			raw_sum = raw_sum + 18'(r.raw_code);
			mv_sum = mv_sum + 18'(r.pin_millivolts);
			burst_count = burst_count + 7'd1;
			if (32'(burst_count) >= SAMPLES) begin
				last_raw_avg = 12'(raw_sum / SAMPLES);
				reading = (64'(mv_sum) * 64'(cfg_gain)) / (64'(SAMPLES) * 64'd16);
				if (reading > 64'hFF_FFFF)
					reading = 64'hFF_FFFF;
				if (!have_reading) begin
					filtered_q8 = 24'(reading);
					have_reading = 1'b1;
				end else begin
					weight = (cfg_alpha > 9'd256) ? 64'd256 : 64'(cfg_alpha);
					filtered_q8 = 24'((64'(filtered_q8) * (64'd256 - weight)
						+ reading * weight) >> 8);
				end
				critical_state = next_flag(critical_state, cfg_crit);
				low_state = next_flag(low_state, cfg_low);
				burst_open = 1'b0;
				burst_count = '0;
				updated = 1'b1;
			end
		end
		o.sampling = burst_open;
		o.updated = updated;
		o.valid_res = have_reading;
		o.low_flag = low_state;
		o.critical_flag = critical_state;
		o.pack_mv = filtered_q8[23:8];
		o.cell_mv = filtered_q8[23:9];
		o.raw_average = last_raw_avg;
		return o;
	endfunction

	task automatic report_error(string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_error($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	function automatic void queue_tick(logic [31:0] now);
		req_t r;
		r.kind = KIND_TICK;
		r.now_ms = now;
		r.raw_code = 12'($urandom);
		r.pin_millivolts = 12'($urandom);
		pending_requests.push_back(r);
		queued_total++;
	endfunction

	function automatic void queue_sample(logic [11:0] raw, logic [11:0] mv);
		req_t r;
		r.kind = KIND_SAMPLE;
		r.now_ms = $urandom;
		r.raw_code = raw;
		r.pin_millivolts = mv;
		pending_requests.push_back(r);
		queued_total++;
	endfunction

	// Pin voltage that lands the pack reading near one of the flag edges.
	function automatic int pick_pin_mv();
		int unsigned thr;
		int          jitter;
		longint      target;
		longint      mv;
		case ($urandom_range(0, 3))
			0: thr = cfg_crit;
			1: thr = cfg_low;
			2: thr = cfg_crit + cfg_hyst;
			default: thr = cfg_low + cfg_hyst;
		endcase
		jitter = int'($urandom_range(0, 800)) - 400;
		target = longint'(thr) + jitter;
		if (target < 0)
			target = 0;
		if (cfg_gain == 0)
			mv = $urandom_range(0, 4095);
		else
			mv = target * 4096 / cfg_gain;
		if (mv > 4095)
			mv = 4095;
		return int'(mv);
	endfunction

	task automatic queue_traffic(int unsigned n_items);
		int unsigned start;
		int unsigned sel;
		int          level;
		int          mv;
		start = queued_total;
		while (queued_total - start < n_items) begin
			sel = $urandom_range(0, 19);
			if (sel < 15) begin
				gen_ms = gen_ms + 32'(cfg_interval) + $urandom_range(0, 3);
				queue_tick(gen_ms);
				level = pick_pin_mv();
				repeat (SAMPLES) begin
					mv = level + int'($urandom_range(0, 40)) - 20;
					if (mv < 0)
						mv = 0;
					if (mv > 4095)
						mv = 4095;
					queue_sample(12'($urandom), 12'(mv));
				end
			end else if (sel < 17) begin
				gen_ms = gen_ms + 32'(cfg_interval) + $urandom_range(0, 3);
				queue_tick(gen_ms);
				repeat ($urandom_range(1, SAMPLES - 1))
					queue_sample(12'($urandom), 12'($urandom));
				queue_tick(gen_ms + $urandom_range(0, 2 * cfg_interval));
			end else if (sel < 18) begin
				queue_tick(gen_ms + $urandom_range(0, 32'(cfg_interval)));
			end else if (sel < 19) begin
				queue_tick($urandom);
			end else begin
				queue_sample(12'($urandom), 12'($urandom));
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || expected_readings.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_INTERVAL: cfg_interval = value[15:0];
			REG_GAIN:     cfg_gain = value[15:0];
			REG_ALPHA:    cfg_alpha = value[8:0];
			REG_CRITICAL: cfg_crit = value[15:0];
			REG_LOW:      cfg_low = value[15:0];
			REG_HYST:     cfg_hyst = value[11:0];
			default: ;
		endcase
	endtask

	task automatic run_phase(int unsigned interval, int unsigned gain, int unsigned alpha,
		int unsigned crit, int unsigned low, int unsigned hyst, int unsigned n_items);
		wait_idle();
		write_reg(REG_INTERVAL, interval);
		write_reg(REG_GAIN, gain);
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_CRITICAL, crit);
		write_reg(REG_LOW, low);
		write_reg(REG_HYST, hyst);
		queue_traffic(n_items);
		wait_idle();
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !req_hold) begin
			if (req_gap == 0 && !quiet_mode) begin
				if (req_calm != 0)
					req_calm--;
				else if ($urandom_range(0, 50) == 0)
					req_calm = $urandom_range(20, 120);
				else if ($urandom_range(0, 5) == 0)
					req_gap = $urandom_range(1, 10);
			end
			if (req_gap != 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				req <= pending_requests[0];
				req_valid <= 1'b1;
				req_hold = 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (req_valid && req_ready) begin
			expected_readings.push_back(predict_reading(req));
			void'(pending_requests.pop_front());
			req_hold = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && results_seen >= 300 && pending_requests.size() > 40) begin
				long_hold_done = 1'b1;
				rsp_gap = 400;
			end else if (rsp_gap == 0 && !quiet_mode) begin
				if (rsp_calm != 0)
					rsp_calm--;
				else if ($urandom_range(0, 50) == 0)
					rsp_calm = $urandom_range(20, 120);
				else if ($urandom_range(0, 5) == 0)
					rsp_gap = $urandom_range(1, 10);
			end
			if (rsp_gap != 0) begin
				rsp_gap--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		rsp_t want;
		if (rsp_valid && rsp_ready) begin
			results_seen++;
			if (expected_readings.size() == 0) begin
				report_error("result with no request outstanding");
			end else begin
				want = expected_readings.pop_front();
				check_field("sampling", rsp.sampling, want.sampling);
				check_field("updated", rsp.updated, want.updated);
				check_field("valid_res", rsp.valid_res, want.valid_res);
				check_field("low_flag", rsp.low_flag, want.low_flag);
				check_field("critical_flag", rsp.critical_flag, want.critical_flag);
				check_field("pack_mv", rsp.pack_mv, want.pack_mv);
				check_field("cell_mv", rsp.cell_mv, want.cell_mv);
				check_field("raw_average", rsp.raw_average, want.raw_average);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed requests on the reset register values.
		queue_sample(12'hFFF, 12'hFFF);
		queue_tick(32'd50);
		queue_tick(32'd100);
		queue_tick(32'hFFFF_FFFF);
		queue_sample(12'd0, 12'd0);
		queue_sample(12'hFFF, 12'hFFF);
		queue_sample(12'hAAA, 12'h555);
		queue_sample(12'h555, 12'hAAA);
		queue_sample(12'hFFF, 12'd0);
		queue_sample(12'd0, 12'hFFF);
		queue_sample(12'd1, 12'd3200);
		queue_sample(12'hFFE, 12'd3200);
		queue_tick(32'hFFFF_FFFF);
		repeat (SAMPLES) queue_sample(12'($urandom), 12'd3000);
		queue_tick(32'd10);
		gen_ms = 32'd10;
		wait_idle();

		run_phase(100, 8192, 26, 6400, 7000, 200, 140);
		run_phase(0, 4096, 256, 3000, 3500, 0, 140);
		run_phase(65535, 65535, 0, 65535, 65535, 4095, 120);
		run_phase(7, 0, 511, 0, 0, 4095, 100);
		run_phase(1, 12000, 300, 5000, 6000, 100, 140);
		run_phase($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 511),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 4095), 140);
		run_phase($urandom_range(0, 500), $urandom_range(4096, 20000), $urandom_range(0, 511),
			$urandom_range(3000, 8000), $urandom_range(3000, 9000), $urandom_range(0, 4095), 140);
		quiet_mode = 1'b1;
		run_phase(20, 9000, 64, 5200, 5800, 150, 110);

		repeat (60) @(posedge clk);
		if (error_count == 0 && expected_readings.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
